>>> rtl/core/toae_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the TCP option address extractor.
package toae_pkg;

    // Largest option area of a TCP header, in bytes.
    localparam int MAX_OPTION_AREA = 40;
    localparam int AREA_W = $clog2(MAX_OPTION_AREA + 1);

    // Result queue depth; one item can push two words.
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    // Input word kinds.
    localparam logic KIND_BEGIN = 1'b0;
    localparam logic KIND_BYTE  = 1'b1;

    // TCP option kinds with special meaning.
    localparam logic [7:0] OPT_EOL = 8'd0;
    localparam logic [7:0] OPT_NOP = 8'd1;

    // Smallest legal size byte: kind plus size.
    localparam logic [7:0] OPT_MIN_SIZE = 8'd2;

    // Result status codes.
    localparam logic [1:0] ST_CAPTURED  = 2'd0;
    localparam logic [1:0] ST_EOL       = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_V4_KIND = 2'd0;
    localparam logic [1:0] CFG_V4_SIZE = 2'd1;
    localparam logic [1:0] CFG_V6_KIND = 2'd2;
    localparam logic [1:0] CFG_V6_SIZE = 2'd3;

    // Configuration reset values.
    localparam logic [7:0] V4_KIND_RST = 8'd254;
    localparam logic [5:0] V4_SIZE_RST = 6'd8;
    localparam logic [7:0] V6_KIND_RST = 8'd253;
    localparam logic [5:0] V6_SIZE_RST = 6'd20;

    // Scanner phases.
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_KIND,
        PH_SIZE,
        PH_SKIP,
        PH_CAPTURE,
        PH_DONE
    } phase_t;

    // One result word.
    typedef struct packed {
        logic [1:0] status;
        logic       is_v6;
        logic [7:0] data_byte;
        logic [5:0] byte_index;
        logic       last;
    } result_t;

    // Result word for a search that ended without a match.
    function automatic result_t not_found(input logic [1:0] st);
        result_t r;
        r.status     = st;
        r.is_v6      = 1'b0;
        r.data_byte  = 8'd0;
        r.byte_index = 6'd0;
        r.last       = 1'b1;
        return r;
    endfunction

    // Result word for one captured option byte.
    function automatic result_t captured(input logic v6, input logic [7:0] b,
                                         input logic [5:0] idx, input logic fin);
        result_t r;
        r.status     = ST_CAPTURED;
        r.is_v6      = v6;
        r.data_byte  = b;
        r.byte_index = idx;
        r.last       = fin;
        return r;
    endfunction

endpackage

>>> rtl/core/tcp_option_address_extractor_core.sv
`timescale 1ns / 1ps
// Top level of the TCP option address extractor: option scanner and result queue.
// The block takes one input word per cycle unless stalled: a begin word with the option
// area length, then the option bytes. It walks the options, and when it finds one whose
// kind and size match the configured v4 or v6 pair it emits that option's bytes, kind and
// size first, the final one marked last; a search that fails emits one word with status
// end-of-list, malformed size or area exhausted. Each word is handled by the scanner
// state registers and lands in a four-word result queue, so a word can be accepted every
// cycle unless the input stalls. The size byte of a matching option yields two result
// words, and the input stalls while the queue has fewer than two free slots, so the input
// rate stays at one word per cycle as long as the output side takes a word per cycle.
module tcp_option_address_extractor_core (
    input  logic       clk,
    input  logic       rst_n,
    // Configuration write port
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // Input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic       kind,
    input  logic [7:0] value,
    // Output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] status,
    output logic       is_v6,
    output logic [7:0] data_byte,
    output logic [5:0] byte_index,
    output logic       last
);
    import toae_pkg::*;

    // Configuration registers.
    logic [7:0] v4_kind_reg;
    logic [5:0] v4_size_reg;
    logic [7:0] v6_kind_reg;
    logic [5:0] v6_size_reg;

    // Scanner state.
    phase_t            phase_reg,       phase_next;
    logic [AREA_W-1:0] remaining_reg,   remaining_next;
    logic [5:0]        option_size_reg, option_size_next;
    logic [7:0]        pending_kind_reg, pending_kind_next;
    logic [5:0]        count_reg,       count_next;
    logic              capture_v6_reg,  capture_v6_next;

    // Result queue.
    result_t              fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] head_reg, head_next;
    logic [OUT_PTR_W-1:0] tail_reg, tail_next;
    logic [OUT_CNT_W-1:0] fill_reg, fill_next;

    logic              in_accept;
    logic              pop;
    logic              push0;
    logic              push1;
    result_t           res0;
    result_t           res1;
    logic [AREA_W-1:0] rem_dec;
    logic [AREA_W-1:0] begin_len;
    logic [5:0]        cnt_dec;
    logic [5:0]        skip_cnt;
    logic              v4_match;
    logic              v6_match;
    logic              size_bad;
    logic              cap_fin;
    logic [OUT_PTR_W-1:0] tail_plus1;

    // Handshakes: stall while the queue cannot take a two-word burst.
    assign in_stall  = (fill_reg > OUT_CNT_W'(OUT_DEPTH - 2));
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (fill_reg != '0);
    assign pop       = out_valid && !out_stall;

    // Output word comes straight from the queue head.
    assign status     = fifo_reg[head_reg].status;
    assign is_v6      = fifo_reg[head_reg].is_v6;
    assign data_byte  = fifo_reg[head_reg].data_byte;
    assign byte_index = fifo_reg[head_reg].byte_index;
    assign last       = fifo_reg[head_reg].last;

    // Datapath helpers for the current byte.
    assign rem_dec   = remaining_reg - AREA_W'(1);
    assign cnt_dec   = count_reg - 6'd1;
    assign skip_cnt  = value[5:0] - 6'd2;
    assign begin_len = (value > 8'(MAX_OPTION_AREA)) ? AREA_W'(MAX_OPTION_AREA)
                                                     : value[AREA_W-1:0];
    assign size_bad  = (value < OPT_MIN_SIZE)
                    || ({1'b0, value} > (9'(rem_dec) + 9'd2));
    assign v4_match  = (pending_kind_reg == v4_kind_reg) && (value == {2'b00, v4_size_reg});
    assign v6_match  = (pending_kind_reg == v6_kind_reg) && (value == {2'b00, v6_size_reg});
    assign cap_fin   = ({1'b0, count_reg} + 7'd1) >= {1'b0, option_size_reg};

    // Scanner next state and result words.
    always_comb
    begin
        phase_next        = phase_reg;
        remaining_next    = remaining_reg;
        option_size_next  = option_size_reg;
        pending_kind_next = pending_kind_reg;
        count_next        = count_reg;
        capture_v6_next   = capture_v6_reg;
        push0             = 1'b0;
        push1             = 1'b0;
        res0              = not_found(ST_EXHAUSTED);
        res1              = not_found(ST_EXHAUSTED);

        if (in_accept)
        begin
            if (kind == KIND_BEGIN)
            begin
                // A begin word restarts the scan from any phase.
                remaining_next    = begin_len;
                option_size_next  = '0;
                pending_kind_next = '0;
                count_next        = '0;
                capture_v6_next   = 1'b0;
                if (begin_len == '0)
                begin
                    push0      = 1'b1;
                    phase_next = PH_DONE;
                end
                else
                begin
                    phase_next = PH_KIND;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_KIND:
                    begin
                        remaining_next = rem_dec;
                        if (value == OPT_EOL)
                        begin
                            push0      = 1'b1;
                            res0       = not_found(ST_EOL);
                            phase_next = PH_DONE;
                        end
                        else if (rem_dec == '0)
                        begin
                            // NOP or a kind byte that uses up the area.
                            push0      = 1'b1;
                            phase_next = PH_DONE;
                        end
                        else if (value == OPT_NOP)
                        begin
                            phase_next = PH_KIND;
                        end
                        else
                        begin
                            pending_kind_next = value;
                            phase_next        = PH_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        remaining_next = rem_dec;
                        if (size_bad)
                        begin
                            push0      = 1'b1;
                            res0       = not_found(ST_MALFORMED);
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            option_size_next = value[5:0];
                            if (v4_match || v6_match)
                            begin
                                // Emit kind and size together.
                                capture_v6_next = !v4_match;
                                push0 = 1'b1;
                                push1 = 1'b1;
                                res0  = captured(!v4_match, pending_kind_reg, 6'd0, 1'b0);
                                res1  = captured(!v4_match, value, 6'd1,
                                                 value == OPT_MIN_SIZE);
                                if (value == OPT_MIN_SIZE)
                                begin
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    count_next = 6'd2;
                                    phase_next = PH_CAPTURE;
                                end
                            end
                            else
                            begin
                                count_next = skip_cnt;
                                if (skip_cnt != '0)
                                begin
                                    phase_next = PH_SKIP;
                                end
                                else if (rem_dec == '0)
                                begin
                                    push0      = 1'b1;
                                    phase_next = PH_DONE;
                                end
                                else
                                begin
                                    phase_next = PH_KIND;
                                end
                            end
                        end
                    end
                    PH_SKIP:
                    begin
                        remaining_next = rem_dec;
                        count_next     = cnt_dec;
                        if (cnt_dec == '0)
                        begin
                            if (rem_dec == '0)
                            begin
                                push0      = 1'b1;
                                phase_next = PH_DONE;
                            end
                            else
                            begin
                                phase_next = PH_KIND;
                            end
                        end
                    end
                    PH_CAPTURE:
                    begin
                        remaining_next = rem_dec;
                        push0          = 1'b1;
                        res0           = captured(capture_v6_reg, value, count_reg, cap_fin);
                        if (cap_fin)
                        begin
                            phase_next = PH_DONE;
                        end
                        else
                        begin
                            count_next = count_reg + 6'd1;
                        end
                    end
                    default:
                    begin
                        // Idle or done: stray bytes are dropped.
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // Queue pointer and fill updates.
    assign tail_plus1 = tail_reg + OUT_PTR_W'(1);

    always_comb
    begin
        head_next = pop ? head_reg + OUT_PTR_W'(1) : head_reg;
        tail_next = tail_reg + OUT_PTR_W'(push0) + OUT_PTR_W'(push1);
        fill_next = fill_reg + OUT_CNT_W'(push0) + OUT_CNT_W'(push1) - OUT_CNT_W'(pop);
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_kind_reg <= V4_KIND_RST;
            v4_size_reg <= V4_SIZE_RST;
            v6_kind_reg <= V6_KIND_RST;
            v6_size_reg <= V6_SIZE_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_V4_KIND: v4_kind_reg <= cfg_data;
                CFG_V4_SIZE: v4_size_reg <= cfg_data[5:0];
                CFG_V6_KIND: v6_kind_reg <= cfg_data;
                CFG_V6_SIZE: v6_size_reg <= cfg_data[5:0];
                default:     v4_kind_reg <= v4_kind_reg;
            endcase
        end
    end

    // Scanner state and queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            remaining_reg    <= '0;
            option_size_reg  <= '0;
            pending_kind_reg <= '0;
            count_reg        <= '0;
            capture_v6_reg   <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            fill_reg         <= '0;
        end
        else
        begin
            phase_reg        <= phase_next;
            remaining_reg    <= remaining_next;
            option_size_reg  <= option_size_next;
            pending_kind_reg <= pending_kind_next;
            count_reg        <= count_next;
            capture_v6_reg   <= capture_v6_next;
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            fill_reg         <= fill_next;
        end
    end

    // Queue storage: payload only, no reset.
    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            fifo_reg[tail_reg] <= res0;
        end
        if (push1)
        begin
            fifo_reg[tail_plus1] <= res1;
        end
    end

endmodule

>>> rtl/core/toae_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the TCP option address extractor, with its bind.
module toae_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       kind,
    input logic [7:0] value,
    input logic       out_valid,
    input logic       out_stall,
    input logic [1:0] status,
    input logic       is_v6,
    input logic [7:0] data_byte,
    input logic [5:0] byte_index,
    input logic       last
);
    import toae_pkg::*;

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(is_v6)
            && $stable(data_byte) && $stable(byte_index) && $stable(last))
        else $error("stalled output word changed");

    // The input only stalls while results are waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no pending result");

    // An empty option area answers in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_BEGIN) && (value == 8'd0) |=> out_valid)
        else $error("empty option area gave no result");

    // Coming out of reset the queue is empty and the input is open.
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid && !in_stall)
        else $error("queue not empty after reset");

endmodule

bind tcp_option_address_extractor_core toae_checker u_toae_checker (.*);

>>> test/tcp_option_address_extractor_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the TCP option address extractor core.
module tcp_option_address_extractor_core_tb;
    import toae_pkg::*;

    localparam int CLK_PERIOD     = 12;
    localparam int RESET_CYCLES   = 9;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int FIRST_QUOTA    = 150;
    localparam int PHASE_QUOTA    = 125;
    localparam int NUM_SETUPS     = 5;
    localparam int NUM_ROWS       = 27;
    localparam logic [5:0] AREA_CAP = 6'(MAX_OPTION_AREA);

    // One input word, and one row of the directed table.
    typedef struct packed {
        logic       k;
        logic [7:0] v;
    } word_t;

    typedef struct packed {
        logic       k;
        logic [7:0] v;
        logic       typed;
        logic [1:0] st;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       kind;
    logic [7:0] value;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] status;
    logic       is_v6;
    logic [7:0] data_byte;
    logic [5:0] byte_index;
    logic       last;

    // Scanner state and register copies of the predictor.
    phase_t     scan_phase;
    logic [5:0] area_left;
    logic [7:0] opt_size;
    logic [7:0] opt_kind;
    logic [5:0] byte_count;
    logic       want_v6;
    logic [7:0] v4_kind_reg;
    logic [5:0] v4_size_reg;
    logic [7:0] v6_kind_reg;
    logic [5:0] v6_size_reg;

    result_t step_results[$];
    result_t expected_words[$];
    word_t   segment_words[$];

    int error_count;
    int idle_cycles;
    int items_sent;
    bit steady;

    tcp_option_address_extractor_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .value      (value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .is_v6      (is_v6),
        .data_byte  (data_byte),
        .byte_index (byte_index),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    function automatic result_t make_word(input logic [1:0] st, input logic v6,
                                          input logic [7:0] b, input logic [5:0] idx,
                                          input logic fin);
        result_t r;
        r.status     = st;
        r.is_v6      = v6;
        r.data_byte  = b;
        r.byte_index = idx;
        r.last       = fin;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // The search is over without a match: one word, marked last.
    task automatic end_search(input logic [1:0] st);
        step_results.push_back(make_word(st, 1'b0, 8'd0, 6'd0, 1'b1));
        scan_phase = PH_DONE;
    endtask

    // After a begin word, a NOP or a skipped option the scan goes on unless the area is used up.
    task automatic resume_scan();
        if (area_left == 0)
            end_search(ST_EXHAUSTED);
        else
            scan_phase = PH_KIND;
    endtask

    // Works out the result words that one accepted input word causes.
    task automatic predict_word(input logic k, input logic [7:0] b);
        logic matched;
        logic fin;
        step_results.delete();
        if (k == KIND_BEGIN)
        begin
            area_left  = (b > MAX_OPTION_AREA) ? AREA_CAP : b[5:0];
            opt_size   = 8'd0;
            opt_kind   = 8'd0;
            byte_count = 6'd0;
            want_v6    = 1'b0;
            resume_scan();
        end
        else
        begin
            case (scan_phase)
                PH_KIND:
                begin
                    area_left = area_left - 6'd1;
                    if (b == OPT_EOL)
                        end_search(ST_EOL);
                    else if (b == OPT_NOP)
                        resume_scan();
                    else if (area_left == 0)
                        end_search(ST_EXHAUSTED);
                    else
                    begin
                        opt_kind   = b;
                        scan_phase = PH_SIZE;
                    end
                end
                PH_SIZE:
                begin
                    area_left = area_left - 6'd1;
                    if (b < OPT_MIN_SIZE || int'(b) > int'(area_left) + 2)
                        end_search(ST_MALFORMED);
                    else
                    begin
                        opt_size = b;
                        matched  = 1'b1;
                        if (opt_kind == v4_kind_reg && b == {2'b00, v4_size_reg})
                            want_v6 = 1'b0;
                        else if (opt_kind == v6_kind_reg && b == {2'b00, v6_size_reg})
                            want_v6 = 1'b1;
                        else
                            matched = 1'b0;
                        if (matched)
                        begin
                            step_results.push_back(
                                make_word(ST_CAPTURED, want_v6, opt_kind, 6'd0, 1'b0));
                            step_results.push_back(
                                make_word(ST_CAPTURED, want_v6, b, 6'd1, b == OPT_MIN_SIZE));
                            if (b == OPT_MIN_SIZE)
                                scan_phase = PH_DONE;
                            else
                            begin
                                byte_count = 6'd2;
                                scan_phase = PH_CAPTURE;
                            end
                        end
                        else
                        begin
                            byte_count = b[5:0] - 6'd2;
                            if (byte_count == 0)
                                resume_scan();
                            else
                                scan_phase = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    area_left  = area_left - 6'd1;
                    byte_count = byte_count - 6'd1;
                    if (byte_count == 0)
                        resume_scan();
                end
                PH_CAPTURE:
                begin
                    area_left = area_left - 6'd1;
                    fin = (int'(byte_count) + 1 >= int'(opt_size));
                    step_results.push_back(make_word(ST_CAPTURED, want_v6, b, byte_count, fin));
                    if (fin)
                        scan_phase = PH_DONE;
                    else
                        byte_count = byte_count + 6'd1;
                end
                default:
                begin
                end
            endcase
        end
    endtask

    // Mostly no gap, sometimes a short one, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one word and holds it until the block takes it.
    task automatic drive_word(input logic k, input logic [7:0] v,
                              input logic typed, input logic [1:0] st);
        int gap;
        bit took;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        took = 1'b0;
        while (!took)
        begin
            @(negedge clk);
            took = (in_stall === 1'b0);
            if (took)
            begin
                predict_word(k, v);
                if (typed)
                    expected_words.push_back(make_word(st, 1'b0, 8'd0, 6'd0, 1'b1));
                else
                    foreach (step_results[i])
                        expected_words.push_back(step_results[i]);
                items_sent++;
            end
            @(posedge clk);
        end
    endtask

    // Kind byte, size byte and random body; a size below two means the kind byte alone.
    task automatic push_option(input logic [7:0] k, input int sz);
        segment_words.push_back(word_t'{KIND_BYTE, k});
        if (sz >= 2)
        begin
            segment_words.push_back(word_t'{KIND_BYTE, sz[7:0]});
            repeat (sz - 2)
                segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(0, 255))});
        end
    endtask

    // Builds one segment: a begin word and a mostly well-formed option list.
    task automatic plan_segment();
        int len;
        int rem;
        int sel;
        int sz;
        logic [7:0] k;
        segment_words.delete();
        sel = $urandom_range(0, 99);
        if (sel < 5)
            len = 0;
        else if (sel < 12)
            len = $urandom_range(MAX_OPTION_AREA + 1, 255);
        else if (sel < 27)
            len = MAX_OPTION_AREA;
        else
            len = $urandom_range(1, MAX_OPTION_AREA);
        segment_words.push_back(word_t'{KIND_BEGIN, len[7:0]});
        rem = (len > MAX_OPTION_AREA) ? MAX_OPTION_AREA : len;
        while (rem > 0)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 12)
            begin
                segment_words.push_back(word_t'{KIND_BYTE, OPT_NOP});
                rem--;
            end
            else if (sel < 55)
            begin
                // Aim at one of the configured address options.
                if (sel < 35)
                begin
                    k  = v4_kind_reg;
                    sz = int'(v4_size_reg);
                end
                else
                begin
                    k  = v6_kind_reg;
                    sz = int'(v6_size_reg);
                end
                if (sz > rem)
                    sz = (rem >= 2) ? $urandom_range(2, rem) : 1;
                push_option(k, sz);
                rem -= sz;
            end
            else if (sel < 82)
            begin
                k  = 8'($urandom_range(2, 255));
                sz = (rem >= 2) ? $urandom_range(2, (rem < 12) ? rem : 12) : 1;
                push_option(k, sz);
                rem -= sz;
            end
            else if (sel < 86)
            begin
                segment_words.push_back(word_t'{KIND_BYTE, OPT_EOL});
                rem = 0;
            end
            else if (sel < 92)
            begin
                // Size byte that is too small or overruns the area.
                segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(2, 255))});
                if ($urandom_range(0, 1) == 0 || rem >= 255)
                    segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(0, 1))});
                else
                    segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(rem + 1, 255))});
                rem = 0;
            end
            else
            begin
                segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(0, 255))});
                rem--;
            end
        end
        // Trailing bytes past the area, or a segment cut short by the next begin.
        sel = $urandom_range(0, 99);
        if (sel < 15)
        begin
            repeat ($urandom_range(1, 4))
                segment_words.push_back(word_t'{KIND_BYTE, 8'($urandom_range(0, 255))});
        end
        else if (sel < 25 && segment_words.size() > 2)
        begin
            repeat ($urandom_range(1, segment_words.size() - 2))
                void'(segment_words.pop_back());
        end
    endtask

    task automatic run_random(input int quota);
        int stop;
        stop = items_sent + quota;
        while (items_sent < stop)
        begin
            plan_segment();
            steady = ($urandom_range(0, 9) == 0);
            foreach (segment_words[i])
                drive_word(segment_words[i].k, segment_words[i].v, 1'b0, ST_CAPTURED);
        end
    endtask

    // Waits until every expected word has come out and the block is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        case (idx)
            CFG_V4_KIND: v4_kind_reg = d;
            CFG_V4_SIZE: v4_size_reg = d[5:0];
            CFG_V6_KIND: v6_kind_reg = d;
            CFG_V6_SIZE: v6_size_reg = d[5:0];
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    // Result side: checks each taken word and stalls at random.
    initial
    begin
        result_t seen;
        result_t want;
        bit took;
        int stall_left;
        int r;
        stall_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            took = (out_valid === 1'b1) && (out_stall === 1'b0);
            seen = {status, is_v6, data_byte, byte_index, last};
            @(posedge clk);
            if (took)
            begin
                if (expected_words.size() == 0)
                    report_mismatch($sformatf("unexpected word %h", seen));
                else
                begin
                    want = expected_words.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  seen.status, want.status));
                    if (seen.is_v6 !== want.is_v6)
                        report_mismatch($sformatf("is_v6 got %0d expected %0d",
                                                  seen.is_v6, want.is_v6));
                    if (seen.data_byte !== want.data_byte)
                        report_mismatch($sformatf("data_byte got %h expected %h",
                                                  seen.data_byte, want.data_byte));
                    if (seen.byte_index !== want.byte_index)
                        report_mismatch($sformatf("byte_index got %0d expected %0d",
                                                  seen.byte_index, want.byte_index));
                    if (seen.last !== want.last)
                        report_mismatch($sformatf("last got %0d expected %0d",
                                                  seen.last, want.last));
                end
            end
            if (steady)
            begin
                stall_left = 0;
                out_stall <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 75)
                    out_stall <= 1'b0;
                else
                begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run when no word moves on either side for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(negedge clk);
            if ((in_valid === 1'b1 && in_stall === 1'b0) ||
                (out_valid === 1'b1 && out_stall === 1'b0))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, then random segments under several settings.
    initial
    begin
        row_t rows [NUM_ROWS];
        logic [7:0] setups [NUM_SETUPS][4];
        rst_n     <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_V4_KIND;
        cfg_data  <= 8'd0;
        in_valid  <= 1'b0;
        kind      <= KIND_BEGIN;
        value     <= 8'd0;
        scan_phase  = PH_IDLE;
        area_left   = 6'd0;
        opt_size    = 8'd0;
        opt_kind    = 8'd0;
        byte_count  = 6'd0;
        want_v6     = 1'b0;
        v4_kind_reg = V4_KIND_RST;
        v4_size_reg = V4_SIZE_RST;
        v6_kind_reg = V6_KIND_RST;
        v6_size_reg = V6_SIZE_RST;
        error_count = 0;
        items_sent  = 0;
        steady      = 1'b0;

        rows = '{
            // Stray byte while idle.
            '{KIND_BYTE,  8'h55,   1'b0, ST_CAPTURED},
            // Empty area.
            '{KIND_BEGIN, 8'd0,    1'b1, ST_EXHAUSTED},
            // NOP, then end-of-list.
            '{KIND_BEGIN, 8'd4,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  OPT_NOP, 1'b0, ST_CAPTURED},
            '{KIND_BYTE,  OPT_EOL, 1'b1, ST_EOL},
            // Size byte below two.
            '{KIND_BEGIN, 8'd3,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd9,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd1,    1'b1, ST_MALFORMED},
            // Oversized length saturates; v4 option captured, then a stray byte.
            '{KIND_BEGIN, 8'd255,  1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd254,  1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd8,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'h00,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'hFF,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'h80,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'h7F,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'h01,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'hFE,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'hAA,   1'b0, ST_CAPTURED},
            // Kind byte as the last byte of the area.
            '{KIND_BEGIN, 8'd1,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'hFF,   1'b1, ST_EXHAUSTED},
            // Begin in the middle of a scan; a NOP then empties the area.
            '{KIND_BEGIN, 8'd10,   1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd7,    1'b0, ST_CAPTURED},
            '{KIND_BEGIN, 8'd1,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  OPT_NOP, 1'b1, ST_EXHAUSTED},
            // Size byte that overruns the area.
            '{KIND_BEGIN, 8'd6,    1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd253,  1'b0, ST_CAPTURED},
            '{KIND_BYTE,  8'd20,   1'b1, ST_MALFORMED}
        };

        // v4 kind, v4 size, v6 kind, v6 size for each random phase.
        setups = '{
            '{8'd255, 8'd2,  8'd2,   8'd40},
            '{8'd0,   8'd40, 8'd255, 8'd2},
            '{8'd1,   8'd5,  8'd128, 8'd5},
            '{8'd77,  8'd12, 8'd77,  8'd12},
            '{8'd200, 8'd40, 8'd201, 8'd2}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            drive_word(rows[i].k, rows[i].v, rows[i].typed, rows[i].st);
        run_random(FIRST_QUOTA);

        for (int s = 0; s < NUM_SETUPS; s++)
        begin
            settle();
            write_reg(CFG_V4_KIND, setups[s][0]);
            write_reg(CFG_V4_SIZE, setups[s][1]);
            write_reg(CFG_V6_KIND, setups[s][2]);
            write_reg(CFG_V6_SIZE, setups[s][3]);
            cfg_write <= 1'b0;
            run_random(PHASE_QUOTA);
        end
        settle();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
